[rtl/cfe_pkg.sv]
// ----------------------------------------------------------------------------
// cfe_pkg
// Types, codes and tables shared by the command frame engine modules.
// ----------------------------------------------------------------------------
package cfe_pkg;

   // item kinds on the request channel
   localparam logic KIND_RX = 1'b0;
   localparam logic KIND_TX = 1'b1;

   // result types on the response channel
   localparam logic [1:0] RT_CMD  = 2'd0;
   localparam logic [1:0] RT_FAIL = 2'd1;
   localparam logic [1:0] RT_TX   = 2'd2;

   localparam logic [7:0] RESP_MARK      = 8'h80;
   localparam logic [7:0] ERR_BYTE       = 8'hFF;
   localparam logic [7:0] OPCODE_LIMIT   = 8'd8;
   localparam logic [2:0] NO_RESP_OPCODE = 3'd6;

   // one result item
   typedef struct packed {
      logic [1:0]  result_type;
      logic [2:0]  cmd_opcode;
      logic [63:0] cmd_payload;
      logic [7:0]  tx_byte;
      logic        last;
   } cfe_rsp_type;

   // what the request stage hands to the output serializer
   typedef struct packed {
      cfe_rsp_type item;   // first result of the run
      logic [63:0] data;   // remaining transmit bytes, low byte first
      logic [3:0]  left;   // results still to follow the first one
   } cfe_load_type;

   // frame length in bytes, opcode and checksum included
   function automatic logic [3:0] frame_len(input logic [2:0] op);
      logic [3:0] len;
      case (op)
         3'd0:    len = 4'd10;
         3'd3:    len = 4'd3;
         3'd7:    len = 4'd3;
         default: len = 4'd2;
      endcase
      return len;
   endfunction

   // data bytes sent between the marked opcode and the checksum
   function automatic logic [3:0] resp_data_cnt(input logic [2:0] op);
      logic [3:0] cnt;
      case (op)
         3'd0:    cnt = 4'd8;
         3'd1:    cnt = 4'd8;
         3'd2:    cnt = 4'd0;
         default: cnt = 4'd1;
      endcase
      return cnt;
   endfunction

endpackage

[rtl/checksummed_command_frame_engine.sv]
// ----------------------------------------------------------------------------
// checksummed_command_frame_engine
// Host command link engine: frames received bytes into checksummed commands
// and serializes responses into checksummed byte runs.
// ----------------------------------------------------------------------------
// A request of kind 0 carries one byte received from the host; the first byte
// of a frame is the opcode and picks the frame length (10, 2, 2, 3, 2, 2, 2, 3
// bytes for opcodes 0 to 7). Once the frame is complete, a zero byte sum
// gives one command result with the little-endian payload, any other sum a
// failure result with the opcode and a zero payload. A first byte of 8 or
// above gives a single 0xFF transmit byte and starts no frame. A request of
// kind 1 sends the response for resp_opcode as a run of transmit bytes:
// opcode|0x80, the data bytes low byte first, then a checksum that makes the
// run sum to zero; the run ends with rsp_tlast. Opcode 6 sends nothing. Any
// other kind-1 request drops a frame in progress. Received bytes flow at one per
// cycle while the result register is free, through the request register
// and the result register. A response run, 2 to 10 bytes, holds the result
// channel as the serializer moves one byte per cycle while rsp_tready is high;
// requests without a result retire meanwhile, up to the next that has one.
// ----------------------------------------------------------------------------
module checksummed_command_frame_engine (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // rx_byte[7:0], resp_opcode[10:8],
                                   // resp_data[74:11], zero[79:75]
   input  logic        req_tuser,  // kind

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // cmd_opcode[2:0], cmd_payload[66:3],
                                   // tx_byte[74:67], zero[79:75]
   output logic [1:0]  rsp_tuser,  // result_type
   output logic        rsp_tlast   // last
);

   // request register
   logic        s1_valid_ff;
   logic        s1_kind_ff;
   logic [7:0]  s1_rx_ff;
   logic [2:0]  s1_op_ff;
   logic [63:0] s1_data_ff;

   logic                  s1_adv;
   logic                  s1_silent;
   logic                  out_free;
   logic                  frm_has;
   cfe_pkg::cfe_rsp_type  frm_result;
   cfe_pkg::cfe_load_type load_req;
   cfe_pkg::cfe_rsp_type  out_item;
   logic                  frm_step;
   logic                  frm_abort;
   logic                  load;
   logic [3:0]            data_cnt;

   // a request with no result retires at once; one with a result waits for
   // the result register to come free
   assign s1_silent = (s1_kind_ff == cfe_pkg::KIND_RX) ? !frm_has
                                                       : (s1_op_ff == cfe_pkg::NO_RESP_OPCODE);
   assign s1_adv     = s1_valid_ff && (s1_silent || out_free);
   assign req_tready = !s1_valid_ff || s1_adv;

   assign frm_step  = s1_adv && (s1_kind_ff == cfe_pkg::KIND_RX);
   assign frm_abort = s1_adv && (s1_kind_ff == cfe_pkg::KIND_TX)
                      && (s1_op_ff != cfe_pkg::NO_RESP_OPCODE);
   assign load      = s1_adv && !s1_silent;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_kind_ff <= req_tuser;
         s1_rx_ff   <= req_tdata[7:0];
         s1_op_ff   <= req_tdata[10:8];
         s1_data_ff <= req_tdata[74:11];
      end
   end

   cfe_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .step       (frm_step),
      .abort      (frm_abort),
      .rx_byte    (s1_rx_ff),
      .has_result (frm_has),
      .result     (frm_result)
   );

   // build what the serializer loads: a single frame result, or the head of
   // a response run with its data bytes and checksum still to follow
   always_comb begin
      data_cnt = cfe_pkg::resp_data_cnt(s1_op_ff);
      load_req = '0;
      if (s1_kind_ff == cfe_pkg::KIND_RX) begin
         load_req.item = frm_result;
      end else begin
         load_req.item.result_type = cfe_pkg::RT_TX;
         load_req.item.tx_byte     = {5'd0, s1_op_ff} | cfe_pkg::RESP_MARK;
         load_req.data             = s1_data_ff;
         load_req.left             = data_cnt + 4'd1;
      end
   end

   cfe_txser u_txser (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_req  (load_req),
      .free      (out_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {5'd0, out_item.tx_byte, out_item.cmd_payload, out_item.cmd_opcode};
   assign rsp_tuser = out_item.result_type;
   assign rsp_tlast = out_item.last;

endmodule

[rtl/cfe_frame.sv]
// ----------------------------------------------------------------------------
// cfe_frame
// Receive framer: collects host bytes into frames, checks the byte sum and
// builds the decoded, failure or unknown-opcode result.
// ----------------------------------------------------------------------------
module cfe_frame (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,      // retire one received byte
   input  logic                 abort,     // drop any frame in progress
   input  logic [7:0]           rx_byte,
   output logic                 has_result,
   output cfe_pkg::cfe_rsp_type result
);

   logic [3:0]  count_ff,   count_in;
   logic [2:0]  opcode_ff,  opcode_in;
   logic [7:0]  sum_ff,     sum_in;
   logic [63:0] payload_ff, payload_in;

   logic [3:0]  len;
   logic [4:0]  count_inc;
   logic [7:0]  sum_upd;
   logic [63:0] payload_upd;
   logic        insert;

   always_comb begin
      len         = cfe_pkg::frame_len(opcode_ff);
      count_inc   = {1'b0, count_ff} + 5'd1;
      sum_upd     = sum_ff + rx_byte;
      insert      = (count_inc < {1'b0, len}) && (count_ff <= 4'd8);
      payload_upd = payload_ff;
      for (int i = 0; i < 8; i++) begin
         if (insert && (count_ff == 4'(i + 1))) begin
            payload_upd[8*i +: 8] = rx_byte;
         end
      end

      has_result = 1'b0;
      result     = '0;
      count_in   = count_ff;
      opcode_in  = opcode_ff;
      sum_in     = sum_ff;
      payload_in = payload_ff;

      if (count_ff == 4'd0) begin
         if (rx_byte >= cfe_pkg::OPCODE_LIMIT) begin
            has_result         = 1'b1;
            result.result_type = cfe_pkg::RT_TX;
            result.tx_byte     = cfe_pkg::ERR_BYTE;
            result.last        = 1'b1;
         end else begin
            opcode_in  = rx_byte[2:0];
            sum_in     = rx_byte;
            payload_in = '0;
            count_in   = 4'd1;
         end
      end else begin
         sum_in     = sum_upd;
         payload_in = payload_upd;
         count_in   = count_inc[3:0];
         if (count_inc >= {1'b0, len}) begin
            has_result        = 1'b1;
            result.cmd_opcode = opcode_ff;
            result.last       = 1'b1;
            if (sum_upd != 8'd0) begin
               result.result_type = cfe_pkg::RT_FAIL;
            end else begin
               result.result_type = cfe_pkg::RT_CMD;
               result.cmd_payload = payload_upd;
            end
            count_in   = 4'd0;
            sum_in     = 8'd0;
            payload_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= 4'd0;
         opcode_ff  <= 3'd0;
         sum_ff     <= 8'd0;
         payload_ff <= '0;
      end else if (abort) begin
         count_ff   <= 4'd0;
         sum_ff     <= 8'd0;
         payload_ff <= '0;
      end else if (step) begin
         count_ff   <= count_in;
         opcode_ff  <= opcode_in;
         sum_ff     <= sum_in;
         payload_ff <= payload_in;
      end
   end

endmodule

[rtl/cfe_txser.sv]
// ----------------------------------------------------------------------------
// cfe_txser
// Result register and transmit serializer: holds the current result and
// steps a response run out one byte per cycle unless stalled, then a checksum.
// ----------------------------------------------------------------------------
module cfe_txser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  cfe_pkg::cfe_load_type load_req,
   output logic                  free,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cfe_pkg::cfe_rsp_type  out_item
);

   logic                 valid_ff, valid_in;
   cfe_pkg::cfe_rsp_type item_ff,  item_in;
   logic [63:0]          data_ff,  data_in;
   logic [3:0]           left_ff,  left_in;
   logic [7:0]           sum_ff,   sum_in;

   logic taken;

   assign taken     = valid_ff && out_ready;
   assign free      = !valid_ff || (taken && (left_ff == 4'd0));
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      data_in  = data_ff;
      left_in  = left_ff;
      sum_in   = sum_ff;

      if (taken) begin
         if (left_ff == 4'd0) begin
            valid_in = 1'b0;
         end else begin
            item_in             = '0;
            item_in.result_type = cfe_pkg::RT_TX;
            left_in             = left_ff - 4'd1;
            if (left_ff == 4'd1) begin
               // close the run with the checksum
               item_in.tx_byte = 8'd0 - sum_ff;
               item_in.last    = 1'b1;
            end else begin
               item_in.tx_byte = data_ff[7:0];
               sum_in          = sum_ff + data_ff[7:0];
               data_in         = {8'd0, data_ff[63:8]};
            end
         end
      end

      if (load) begin
         valid_in = 1'b1;
         item_in  = load_req.item;
         data_in  = load_req.data;
         left_in  = load_req.left;
         sum_in   = load_req.item.tx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         left_ff  <= 4'd0;
      end else begin
         valid_ff <= valid_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      data_ff <= data_in;
      sum_ff  <= sum_in;
   end

endmodule

[test/checksummed_command_frame_engine_tb.sv]
// ----------------------------------------------------------------------------
// checksummed_command_frame_engine_tb
// Self-checking bench for the host command link engine. A queue of requests
// (framed host bytes, response runs, broken frames and noise) feeds a clocked
// driver; a local link model predicts every result at request acceptance,
// and a clocked monitor compares each accepted result field by field.
// ----------------------------------------------------------------------------
module checksummed_command_frame_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 1000;  // cycles without any handshake
   localparam int DRAIN_CYCLES   = 16;    // covers the longest run plus pipeline latency
   localparam int RANDOM_ITEMS   = 140;

   // one request as queued for the driver, with the idling of its phase
   typedef struct packed {
      logic        kind;
      logic [7:0]  rx_byte;
      logic [2:0]  resp_opcode;
      logic [63:0] resp_data;
      logic [6:0]  idle_pct;
      logic [6:0]  stall_pct;
   } link_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;   // rx_byte[7:0], resp_opcode[10:8],
                                  // resp_data[74:11], zero[79:75]
   logic        req_tuser = 1'b0; // kind

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // cmd_opcode[2:0], cmd_payload[66:3],
                                  // tx_byte[74:67], zero[79:75]
   logic [1:0]  rsp_tuser;        // result_type
   logic        rsp_tlast;        // last

   link_req_type         pending_requests[$];
   cfe_pkg::cfe_rsp_type due_results[$];
   link_req_type         req_on_bus;

   // idling of the phase being queued, and of the request on the bus
   logic [6:0]  idle_now  = '0;
   logic [6:0]  stall_now = '0;
   logic [6:0]  rsp_stall_pct = '0;

   int          mismatches = 0;
   int          quiet_cycles = 0;
   int          queued_count = 0;

   // link model state
   int          frame_count = 0;
   logic [2:0]  frame_op = '0;
   logic [7:0]  frame_sum = '0;
   logic [63:0] frame_payload = '0;

   checksummed_command_frame_engine u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // link model
   // ---------------------------------------------------------------------

   // whole frame length: opcode, payload bytes and checksum
   function automatic int frame_bytes(input logic [2:0] op);
      if (op == 3'd0) return 10;
      if (op == 3'd3 || op == 3'd7) return 3;
      return 2;
   endfunction

   // data bytes between the marked opcode and the checksum of a response
   function automatic int reply_data_bytes(input logic [2:0] op);
      if (op == 3'd0 || op == 3'd1) return 8;
      if (op == 3'd2) return 0;
      return 1;
   endfunction

   function automatic cfe_pkg::cfe_rsp_type make_result(input logic [1:0] rtype,
                                                        input logic [2:0] op,
                                                        input logic [63:0] payload,
                                                        input logic [7:0] tx,
                                                        input logic last);
      cfe_pkg::cfe_rsp_type r;
      r.result_type = rtype;
      r.cmd_opcode  = op;
      r.cmd_payload = payload;
      r.tx_byte     = tx;
      r.last        = last;
      return r;
   endfunction

   task automatic clear_frame();
      frame_count   = 0;
      frame_sum     = '0;
      frame_payload = '0;
   endtask

   // Advance the link model by one accepted request and queue what it emits.
   task automatic frame_and_respond(input link_req_type r);
      int         len;
      logic [7:0] sum;
      logic [7:0] d;
      if (r.kind == cfe_pkg::KIND_RX) begin
         if (frame_count == 0) begin
            // opening byte: opcode, or a lone error byte when out of range
            if (r.rx_byte >= cfe_pkg::OPCODE_LIMIT) begin
               due_results.push_back(make_result(cfe_pkg::RT_TX, 3'd0, 64'd0,
                                                 cfe_pkg::ERR_BYTE, 1'b1));
            end else begin
               frame_op      = r.rx_byte[2:0];
               frame_sum     = r.rx_byte;
               frame_payload = '0;
               frame_count   = 1;
            end
         end else begin
            len = frame_bytes(frame_op);
            frame_sum = frame_sum + r.rx_byte;
            // payload bytes sit between the opcode and the checksum
            if (frame_count + 1 < len && frame_count <= 8)
               frame_payload = frame_payload |
                               ({56'd0, r.rx_byte} << (8 * (frame_count - 1)));
            frame_count++;
            if (frame_count >= len) begin
               if (frame_sum != 8'd0)
                  due_results.push_back(make_result(cfe_pkg::RT_FAIL, frame_op, 64'd0,
                                                    8'd0, 1'b1));
               else
                  due_results.push_back(make_result(cfe_pkg::RT_CMD, frame_op,
                                                    frame_payload, 8'd0, 1'b1));
               clear_frame();
            end
         end
      end else if (r.resp_opcode != cfe_pkg::NO_RESP_OPCODE) begin
         // response run: marked opcode, data low byte first, negated sum
         sum = cfe_pkg::RESP_MARK | {5'd0, r.resp_opcode};
         due_results.push_back(make_result(cfe_pkg::RT_TX, 3'd0, 64'd0, sum, 1'b0));
         for (int i = 0; i < reply_data_bytes(r.resp_opcode); i++) begin
            d = r.resp_data[8*i +: 8];
            sum = sum + d;
            due_results.push_back(make_result(cfe_pkg::RT_TX, 3'd0, 64'd0, d, 1'b0));
         end
         due_results.push_back(make_result(cfe_pkg::RT_TX, 3'd0, 64'd0, 8'd0 - sum,
                                           1'b1));
         clear_frame();
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // ---------------------------------------------------------------------
   // stimulus builders
   // ---------------------------------------------------------------------

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // queue a host byte; fill the unused response fields with noise
   task automatic push_rx(input logic [7:0] b);
      link_req_type r;
      r.kind        = cfe_pkg::KIND_RX;
      r.rx_byte     = b;
      r.resp_opcode = 3'($urandom_range(7, 0));
      r.resp_data   = rand64();
      r.idle_pct    = idle_now;
      r.stall_pct   = stall_now;
      pending_requests.push_back(r);
      queued_count++;
   endtask

   // queue a response request; fill the unused host byte with noise
   task automatic push_tx(input logic [2:0] op, input logic [63:0] data);
      link_req_type r;
      r.kind        = cfe_pkg::KIND_TX;
      r.rx_byte     = 8'($urandom_range(255, 0));
      r.resp_opcode = op;
      r.resp_data   = data;
      r.idle_pct    = idle_now;
      r.stall_pct   = stall_now;
      pending_requests.push_back(r);
      queued_count++;
   endtask

   // queue a full frame; corrupt the checksum unless good is set
   task automatic push_frame(input logic [2:0] op, input logic [63:0] payload,
                             input bit good);
      logic [7:0] sum;
      sum = {5'd0, op};
      push_rx({5'd0, op});
      for (int i = 0; i < frame_bytes(op) - 2; i++) begin
         sum = sum + payload[8*i +: 8];
         push_rx(payload[8*i +: 8]);
      end
      if (good)
         push_rx(8'd0 - sum);
      else
         push_rx(8'd0 - sum + 8'($urandom_range(255, 1)));
   endtask

   // queue the opcode and a few bytes of a frame, never its last byte
   task automatic push_cut_frame(input logic [2:0] op);
      int keep;
      keep = $urandom_range(frame_bytes(op) - 2, 0);
      push_rx({5'd0, op});
      for (int i = 0; i < keep; i++) push_rx(8'($urandom_range(255, 0)));
   endtask

   // ---------------------------------------------------------------------
   // driver: present queued requests, predict at each acceptance
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) frame_and_respond(req_on_bus);
         // the bus is free once the held request moved or nothing was held
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() > 0 &&
                $urandom_range(99, 0) >= pending_requests[0].idle_pct) begin
               req_on_bus = pending_requests.pop_front();
               req_tvalid    <= 1'b1;
               req_tuser     <= req_on_bus.kind;
               req_tdata     <= {5'd0, req_on_bus.resp_data, req_on_bus.resp_opcode,
                                 req_on_bus.rx_byte};
               rsp_stall_pct <= req_on_bus.stall_pct;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: stall at random, check each accepted result in order
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $error("unexpected result: type %0h data %0h last %0b",
                      rsp_tuser, rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               cfe_pkg::cfe_rsp_type want;
               want = due_results.pop_front();
               check_field("result_type", 64'(want.result_type), 64'(rsp_tuser));
               check_field("cmd_opcode",  64'(want.cmd_opcode),  64'(rsp_tdata[2:0]));
               check_field("cmd_payload", want.cmd_payload,      rsp_tdata[66:3]);
               check_field("tx_byte",     64'(want.tx_byte),     64'(rsp_tdata[74:67]));
               check_field("last",        64'(want.last),        64'(rsp_tlast));
            end
         end
         rsp_tready <= ($urandom_range(99, 0) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: drop the run when neither channel moves for too long
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[checksummed_command_frame_engine] ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // sequence: fill the request queue, release reset, wait for completion
   // ---------------------------------------------------------------------
   initial begin
      int pick;
      int target;

      // directed part, no idling: extremes of each field and every opcode
      idle_now  = 7'd0;
      stall_now = 7'd0;
      push_frame(3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);  // longest frame, full payload
      push_frame(3'd7, 64'h0000_0000_0000_0000, 1'b0);  // checksum failure
      push_frame(3'd1, rand64(), 1'b1);                  // opcode and checksum only
      push_rx(8'd8);                                     // first unknown opcode
      push_rx(8'd255);                                   // largest unknown opcode
      push_rx(8'd5);                                     // open a frame ...
      push_tx(3'd4, rand64());                           // ... and drop it with a response
      push_tx(3'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      push_tx(3'd1, 64'h0000_0000_0000_0000);
      push_tx(3'd2, rand64());
      push_tx(3'd3, rand64());
      push_tx(3'd5, rand64());
      push_tx(cfe_pkg::NO_RESP_OPCODE, rand64());        // version response: silent
      push_tx(3'd7, rand64());

      // random part in four idling phases
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_now = 7'd0;  stall_now = 7'd0;  end
            1: begin idle_now = 7'd48; stall_now = 7'd0;  end
            2: begin idle_now = 7'd0;  stall_now = 7'd48; end
            default: begin idle_now = 7'd32; stall_now = 7'd32; end
         endcase
         target = queued_count + RANDOM_ITEMS / 4;
         while (queued_count < target) begin
            pick = $urandom_range(99, 0);
            if (pick < 55)
               push_frame(3'($urandom_range(7, 0)), rand64(), 1'b1);
            else if (pick < 65)
               push_frame(3'($urandom_range(7, 0)), rand64(), 1'b0);
            else if (pick < 80)
               push_tx(3'($urandom_range(7, 0)), rand64());
            else if (pick < 88) begin
               // broken frame: cut short, then a response request
               push_cut_frame(3'($urandom_range(7, 0)));
               push_tx(3'($urandom_range(7, 0)), rand64());
            end else
               push_rx(8'($urandom_range(255, 0)));
         end
      end

      // hold reset, then release at a rising edge
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // wait until every request moved and every result came back
      @(negedge clock);
      while (pending_requests.size() > 0 || req_tvalid || due_results.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && due_results.size() == 0)
         $display("[checksummed_command_frame_engine] OK");
      else
         $display("[checksummed_command_frame_engine] ERROR");
      $finish;
   end

endmodule

[sim.f]
rtl/cfe_pkg.sv
rtl/cfe_frame.sv
rtl/cfe_txser.sv
rtl/checksummed_command_frame_engine.sv
test/checksummed_command_frame_engine_tb.sv
